// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the decoder modules.
// The user module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while in reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_PROP(label, !(expr), msg)

`endif

// ===== sv/cbd_pkg.sv =====
package cbd_pkg;

  // Width of the chunk size accumulator.
  localparam int SizeBits = 32;

  // Result kinds, carried on the output tuser.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_FMT   = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef struct packed {
    logic       final_result;
    logic [1:0] result_kind;
    logic [7:0] body_byte;
  } result_t;

  // Everything one input word produces: none, one or two results.
  typedef struct packed {
    logic    has;
    logic    two;
    result_t r0;
    result_t r1;
  } item_res_t;

  // {valid, value} of an ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== sv/http_chunked_body_decoder.sv =====
// HTTP/1.1 chunked body decoder.
// Input stream (s_axis): one raw body byte per word. tuser marks the first
// byte of a new message and clears the parser before that byte; tlast says
// the connection closed after this byte.
// Output stream (m_axis): one result per word. tuser gives the kind (body
// byte, finished ok, format error, truncated), tdata the body byte for body
// results and zero otherwise, tlast marks the finishing status of a message.
// Size lines are parsed as hex, extensions after ';' are skipped, the two
// bytes after each chunk's data are dropped unchecked, and a zero size ends
// the message. Bytes after the message finished give nothing until tuser.
// Timing: a byte is parsed in the cycle it is accepted; its results appear on
// m_axis from the next cycle on. One byte per cycle is sustained while the
// queue has room. A byte's two results (last data, truncation) go out in turn.
// Results go through a two-entry queue, one entry per input word that gives
// results; s_axis_tready is register-derived and drops only when both entries
// are full, so a stalled receiver backs the input up after two result-bearing
// words without losing anything.
// Reset clears the parser to the start of a size line and empties the queue.
module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] message_start
  input  logic       s_axis_tlast,   // stream_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] body_byte
  output logic [1:0] m_axis_tuser,   // [1:0] result_kind
  output logic       m_axis_tlast    // final_result
);
  import cbd_pkg::*;

  logic      acc;
  item_res_t res;
  result_t   out_res;

  assign acc = s_axis_tvalid && s_axis_tready;

  // Per-byte parse; state advances only on an accepted word.
  cbd_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .data_i  (s_axis_tdata),
    .start_i (s_axis_tuser),
    .end_i   (s_axis_tlast),
    .res_o   (res)
  );

  // Result queue: splits the two sides and serializes paired results.
  cbd_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (acc),
    .item_i    (res),
    .ready_o   (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (out_res)
  );

  assign m_axis_tdata = out_res.body_byte;
  assign m_axis_tuser = out_res.result_kind;
  assign m_axis_tlast = out_res.final_result;

endmodule

// ===== sv/cbd_parser.sv =====
module cbd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        data_i,
  input  logic              start_i,
  input  logic              end_i,
  output cbd_pkg::item_res_t res_o
);
  import cbd_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] PH_SIZE  = 3'd0;
  localparam logic [2:0] PH_CR    = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_SKIPA = 3'd3;
  localparam logic [2:0] PH_SKIPB = 3'd4;

  logic [2:0]          phase_q, phase_d, ph;
  logic [SizeBits-1:0] cnt_q, cnt_d, cnt;
  logic                dd_q, dd_d, dd;
  logic                fin_q, fin_d, fin;
  logic                byte_v, stat_v, trunc;
  logic [1:0]          stat_kind;
  logic [4:0]          hexd;

  always_comb begin
    // A message start clears the parser before this byte.
    ph  = start_i ? PH_SIZE : phase_q;
    cnt = start_i ? '0 : cnt_q;
    dd  = start_i ? 1'b0 : dd_q;
    fin = start_i ? 1'b0 : fin_q;

    phase_d   = ph;
    cnt_d     = cnt;
    dd_d      = dd;
    fin_d     = fin;
    byte_v    = 1'b0;
    stat_v    = 1'b0;
    stat_kind = KIND_OK;
    hexd      = hex_digit(data_i);

    if (!fin) begin
      case (ph)
        PH_SIZE: begin
          if (data_i == CHAR_CR) begin
            phase_d = PH_CR;
          end else if (dd) begin
            // extension byte, skipped
          end else if (data_i == CHAR_SEMI) begin
            dd_d = 1'b1;
          end else if (!hexd[4] || cnt[SizeBits-1 -: 4] != 4'd0) begin
            stat_v    = 1'b1;
            stat_kind = KIND_FMT;
            fin_d     = 1'b1;
          end else begin
            cnt_d = {cnt[SizeBits-5:0], hexd[3:0]};
          end
        end
        PH_CR: begin
          if (data_i == CHAR_LF) begin
            if (cnt == '0) begin
              stat_v    = 1'b1;
              stat_kind = KIND_OK;
              fin_d     = 1'b1;
            end else begin
              phase_d = PH_DATA;
              dd_d    = 1'b0;
            end
          end else if (!dd) begin
            stat_v    = 1'b1;
            stat_kind = KIND_FMT;
            fin_d     = 1'b1;
          end else if (data_i != CHAR_CR) begin
            phase_d = PH_SIZE;
          end
        end
        PH_DATA: begin
          byte_v = 1'b1;
          cnt_d  = cnt - SizeBits'(1);
          if (cnt == SizeBits'(1)) begin
            phase_d = PH_SKIPA;
          end
        end
        PH_SKIPA: begin
          phase_d = PH_SKIPB;
        end
        default: begin
          phase_d = PH_SIZE;
          dd_d    = 1'b0;
          cnt_d   = '0;
        end
      endcase
    end

    trunc = end_i && !fin_d;
    if (trunc) begin
      fin_d = 1'b1;
    end

    res_o.has = byte_v || stat_v || trunc;
    res_o.two = byte_v && trunc;
    res_o.r1  = '{final_result: 1'b1, result_kind: KIND_TRUNC, body_byte: 8'd0};
    if (byte_v) begin
      res_o.r0 = '{final_result: 1'b0, result_kind: KIND_BYTE, body_byte: data_i};
    end else if (stat_v) begin
      res_o.r0 = '{final_result: 1'b1, result_kind: stat_kind, body_byte: 8'd0};
    end else begin
      res_o.r0 = '{final_result: 1'b1, result_kind: KIND_TRUNC, body_byte: 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      cnt_q   <= '0;
      dd_q    <= 1'b0;
      fin_q   <= 1'b0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      dd_q    <= dd_d;
      fin_q   <= fin_d;
    end
  end

  `ASSERT_PROP(a_data_cnt, phase_q == PH_DATA |-> cnt_q != '0, "data phase with zero count")
  `ASSERT_PROP(a_fin_quiet, acc_i && fin_q && !start_i |-> !res_o.has,
               "result after message finished")
  `ASSERT_NEVER(a_phase_rng, phase_q > PH_SKIPB, "phase code out of range")

endmodule

// ===== sv/cbd_outq.sv =====
module cbd_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cbd_pkg::item_res_t item_i,
  output logic               ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output cbd_pkg::result_t   m_res_o
);
  import cbd_pkg::*;
  `include "assert_macros.svh"

  // Two entries, each holding the results of one input word.
  item_res_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q, sub_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop_res, pop_ent;
  item_res_t  head;

  assign head      = mem_q[rd_ptr_q];
  assign ready_o   = cnt_q != 2'd2;
  assign m_valid_o = cnt_q != 2'd0;
  assign m_res_o   = sub_q ? head.r1 : head.r0;
  assign push      = push_i && item_i.has;
  assign pop_res   = m_valid_o && m_ready_i;
  assign pop_ent   = pop_res && (!head.two || sub_q);
  assign cnt_d     = cnt_q + 2'(push) - 2'(pop_ent);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      sub_q    <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ent) begin
        rd_ptr_q <= ~rd_ptr_q;
        sub_q    <= 1'b0;
      end else if (pop_res) begin
        sub_q <= 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_cnt_max, cnt_q == 2'd3, "queue count overflow")
  `ASSERT_PROP(a_sub_two, sub_q |-> m_valid_o && head.two, "second result of a single entry")
  `ASSERT_PROP(a_no_ovf, push |-> cnt_q != 2'd2, "push into full queue")

endmodule

// ===== dv/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 100ps

// Testbench for the chunked body decoder.
// Raw body bytes are pushed in on the input stream under random bursts and gaps.
// A behavioral decoder predicts every result word, and a monitor compares each
// output word field by field against the oldest pending prediction.
// The output side stalls on random patterns and once holds off long enough to
// back up the input.
module tb_http_chunked_body_decoder;
  import cbd_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 8;
  localparam int HoldOffCycles = 400;
  localparam int RandomItems   = 850;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_CR,
    PH_DATA,
    PH_SKIP1,
    PH_SKIP2
  } parse_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic       s_axis_tuser = 1'b0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  http_chunked_body_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Decoder state as the predictor sees it.
  parse_phase_e          pred_phase = PH_SIZE;
  logic [SizeBits-1:0]   chunk_left = '0;
  logic                  ext_seen = 1'b0;
  logic                  msg_done = 1'b0;

  result_t     pending_results_q[$];
  result_t     head_res;
  int unsigned err_cnt = 0;
  int unsigned sent_words = 0;

  // Sender and receiver pacing.
  int unsigned burst_left = 0;
  logic        no_gaps = 1'b0;
  logic        hold_rx = 1'b0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned idle_cycles = 0;

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic [1:0] k,
                                      input logic f);
    result_t r;
    r.body_byte    = b;
    r.result_kind  = k;
    r.final_result = f;
    pending_results_q.push_back(r);
  endfunction

  // Advance the predicted decoder by one accepted byte.
  function automatic void decode_byte(input logic [7:0] c, input logic st, input logic en);
    logic [3:0] nib;
    logic       nib_ok;
    sent_words++;
    if (st) begin
      pred_phase = PH_SIZE;
      chunk_left = '0;
      ext_seen   = 1'b0;
      msg_done   = 1'b0;
    end
    if (!msg_done) begin
      case (pred_phase)
        PH_SIZE: begin
          if (c == CHAR_CR) begin
            pred_phase = PH_CR;
          end else if (!ext_seen) begin
            if (c == CHAR_SEMI) begin
              ext_seen = 1'b1;
            end else begin
              nib_ok = hex_nibble(c, nib);
              // a digit that would shift bits out of the size is an error
              if (!nib_ok || chunk_left[SizeBits-1 -: 4] != 4'd0) begin
                push_result(8'd0, KIND_FMT, 1'b1);
                msg_done = 1'b1;
              end else begin
                chunk_left = {chunk_left[SizeBits-5:0], nib};
              end
            end
          end
        end
        PH_CR: begin
          if (c == CHAR_LF) begin
            if (chunk_left == '0) begin
              push_result(8'd0, KIND_OK, 1'b1);
              msg_done = 1'b1;
            end else begin
              pred_phase = PH_DATA;
              ext_seen   = 1'b0;
            end
          end else if (!ext_seen) begin
            push_result(8'd0, KIND_FMT, 1'b1);
            msg_done = 1'b1;
          end else if (c != CHAR_CR) begin
            pred_phase = PH_SIZE;
          end
        end
        PH_DATA: begin
          push_result(c, KIND_BYTE, 1'b0);
          chunk_left = chunk_left - 1'b1;
          if (chunk_left == '0) pred_phase = PH_SKIP1;
        end
        PH_SKIP1: pred_phase = PH_SKIP2;
        default: begin
          pred_phase = PH_SIZE;
          ext_seen   = 1'b0;
          chunk_left = '0;
        end
      endcase
    end
    if (en && !msg_done) begin
      push_result(8'd0, KIND_TRUNC, 1'b1);
      msg_done = 1'b1;
    end
  endfunction

  // Offer one word and wait for it to be taken; gaps fall between bursts.
  task automatic send_word(input logic [7:0] b, input logic st, input logic lst);
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, st, lst);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_text(input string s, input logic st_first, input logic last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], st_first && i == 0, last_on_end && i == s.len() - 1);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    string digits;
    digits = ($urandom_range(0, 1) == 0) ? "0123456789abcdef" : "0123456789ABCDEF";
    return digits[v];
  endfunction

  // Size line with random case, leading zeros and an optional extension.
  function automatic void put_size_line(ref logic [7:0] q[$], input int unsigned sz);
    string      hs;
    logic [7:0] ch;
    hs = $sformatf("%0h", sz);
    if (sz == 0 && $urandom_range(0, 3) == 0) hs = "";
    repeat ($urandom_range(0, 2)) hs = {"0", hs};
    for (int i = 0; i < hs.len(); i++) begin
      ch = hs[i];
      if (ch >= "a" && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
      q.push_back(ch);
    end
    if ($urandom_range(0, 3) == 0) begin
      q.push_back(CHAR_SEMI);
      repeat ($urandom_range(0, 5)) begin
        ch = 8'($urandom);
        q.push_back(ch);
        // a lone CR in an extension must not be followed by LF or CR
        if (ch == CHAR_CR) q.push_back("x");
      end
    end
    q.push_back(CHAR_CR);
    q.push_back(CHAR_LF);
  endfunction

  task automatic send_random_message();
    logic [7:0]  bytes_q[$];
    int unsigned kind;
    int unsigned sz;
    int unsigned n;
    logic        last_flag;
    logic        skip_start;
    kind       = $urandom_range(0, 19);
    last_flag  = 1'b0;
    skip_start = ($urandom_range(0, 19) == 0);
    if (kind < 3) begin
      // raw noise
      repeat ($urandom_range(1, 10)) bytes_q.push_back(8'($urandom));
      last_flag = $urandom_range(0, 1);
    end else if (kind < 5) begin
      // 8 digits fit the size, a 9th with a nonzero lead overflows
      n = $urandom_range(8, 9);
      bytes_q.push_back(hex_char(4'($urandom_range(1, 15))));
      repeat (n - 1) bytes_q.push_back(hex_char(4'($urandom)));
      bytes_q.push_back(CHAR_CR);
      bytes_q.push_back(CHAR_LF);
      repeat ($urandom_range(1, 6)) bytes_q.push_back(8'($urandom));
      last_flag = 1'b1;
    end else begin
      repeat ($urandom_range(0, 3)) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
        put_size_line(bytes_q, sz);
        repeat (sz) bytes_q.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          bytes_q.push_back(CHAR_CR);
          bytes_q.push_back(CHAR_LF);
        end else begin
          bytes_q.push_back(8'($urandom));
          bytes_q.push_back(8'($urandom));
        end
      end
      put_size_line(bytes_q, 0);
      repeat ($urandom_range(0, 4)) bytes_q.push_back(8'($urandom));
      if (kind < 8) begin
        bytes_q[$urandom_range(0, bytes_q.size() - 1)] = 8'($urandom);
        last_flag = ($urandom_range(0, 2) == 0);
      end else if (kind < 11) begin
        n = $urandom_range(0, bytes_q.size() - 1);
        while (bytes_q.size() > n + 1) void'(bytes_q.pop_back());
        last_flag = 1'b1;
      end else begin
        last_flag = ($urandom_range(0, 2) == 0);
      end
    end
    foreach (bytes_q[i]) begin
      send_word(bytes_q[i], (i == 0 && !skip_start) || $urandom_range(0, 199) == 0,
                last_flag && i == bytes_q.size() - 1);
    end
  endtask

  // Extension with a lone CR, data bytes at both extremes, ignored tail.
  task automatic test_extension_and_skip();
    send_text("2;\rq\r\n", 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_text("0\r\n", 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    drain();
  endtask

  // Non-hex digit, CR without LF, size overflow.
  task automatic test_format_errors();
    send_text("g", 1'b1, 1'b0);
    send_text("1\rx", 1'b1, 1'b0);
    send_text("100000000", 1'b1, 1'b0);
    drain();
  endtask

  // Empty size line ending with close; close on a data byte.
  task automatic test_empty_line_and_truncation();
    send_text("\r\n", 1'b1, 1'b1);
    send_text("F\r\n", 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
    drain();
  endtask

  // Receiver holds off while the sender streams back to back.
  task automatic test_backpressure();
    string hdr;
    no_gaps = 1'b1;
    hdr = "20\r\n";
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      begin
        send_text(hdr, 1'b1, 1'b0);
        for (int i = 0; i < 32; i++) send_word(8'(i * 8 + 1), 1'b0, 1'b0);
        send_text("\r\n0\r\n\r\n", 1'b0, 1'b0);
      end
    join
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    while (sent_words < RandomItems) send_random_message();
    drain();
  endtask

  // Output pacing: a pattern chosen per stretch, forced low during hold-off.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    if (hold_rx) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results_q.size() == 0) begin
        $error("unexpected result: kind %0d data %02h last %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        head_res = pending_results_q.pop_front();
        if (m_axis_tdata !== head_res.body_byte) begin
          $error("body_byte: expected %02h, got %02h", head_res.body_byte, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser !== head_res.result_kind) begin
          $error("result_kind: expected %0d, got %0d", head_res.result_kind, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tlast !== head_res.final_result) begin
          $error("final_result: expected %0b, got %0b", head_res.final_result, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Stops the run when neither side moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_http_chunked_body_decoder: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extension_and_skip();
    test_format_errors();
    test_empty_line_and_truncation();
    test_backpressure();
    test_random_traffic();
    if (pending_results_q.size() != 0) begin
      $error("%0d results never arrived", pending_results_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_http_chunked_body_decoder: clean");
    end else begin
      $display("tb_http_chunked_body_decoder: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cbd_pkg.sv
sv/cbd_parser.sv
sv/cbd_outq.sv
sv/http_chunked_body_decoder.sv
dv/tb_http_chunked_body_decoder.sv
